// ----- rtl/cbh_pkg.sv -----
// Shared types and constants for the baud-hunt command sequencer.
// No dependencies; used by cbh_step and at_command_baud_hunt_sequencer.
package cbh_pkg;

    // Marker for "no rate chosen"
    localparam logic [3:0] NO_RATE   = 4'hF;
    localparam logic [3:0] HUNT_LEN  = 4'd8;
    localparam logic [3:0] RATE_MAX  = 4'd8;
    localparam logic [3:0] RATE_MIN  = 4'd1;

    // Event kinds carried in the input tuser
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_REPLY = 2'd1;

    // Reply characters
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_Z    = 8'h5A;

    // Sequencer state
    typedef struct packed {
        logic       running;
        logic [3:0] cmd_pos;
        logic [3:0] cur_rate;
        logic [3:0] prev_rate;
        logic [3:0] hunt_pos;
    } t_state;

    // One result item
    typedef struct packed {
        logic       success;
        logic       finished;
        logic       restore_saved_speed;
        logic [1:0] command_index;
        logic       send_command;
        logic [3:0] port_baud_index;
        logic       reconfigure_port;
    } t_result;

    // Rate preference order: 9600, 38400, 115200, then the rest downwards
    function automatic logic [3:0] hunt_rate(input logic [2:0] idx);
        logic [3:0] r;
        unique case (idx)
            3'd0:    r = 4'd4;
            3'd1:    r = 4'd6;
            3'd2:    r = 4'd8;
            3'd3:    r = 4'd7;
            3'd4:    r = 4'd5;
            3'd5:    r = 4'd3;
            3'd6:    r = 4'd2;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/cbh_step.sv -----
// Combinational step of the sequencer: judges one event and gives the next state and result.
// Depends on cbh_pkg.
module cbh_step #(
    parameter int NUM_COMMANDS      = 4,
    parameter int BAUD_COMMAND_SLOT = 1
) (
    input  cbh_pkg::t_state  i_state,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_reply_first,
    input  logic [7:0]       i_reply_second,
    input  logic [3:0]       i_target,
    output cbh_pkg::t_state  o_state,
    output cbh_pkg::t_result o_result
);

    logic            accepted;
    logic            restore;
    logic            reconf;
    logic            active;
    cbh_pkg::t_state s;

    // Reply is OK or '+' followed by an upper-case letter
    assign accepted = (i_mode == cbh_pkg::MODE_REPLY) &&
                      (((i_reply_first == cbh_pkg::CH_O) && (i_reply_second == cbh_pkg::CH_K)) ||
                       ((i_reply_first == cbh_pkg::CH_PLUS) &&
                        (i_reply_second >= cbh_pkg::CH_A) && (i_reply_second <= cbh_pkg::CH_Z)));

    always_comb begin
        s        = i_state;
        o_result = '0;
        restore  = 1'b0;
        reconf   = 1'b0;
        active   = 1'b1;

        // Judge the event against the command last sent
        if (i_mode == cbh_pkg::MODE_START) begin
            s.running   = 1'b1;
            s.cmd_pos   = '0;
            s.cur_rate  = cbh_pkg::NO_RATE;
            s.prev_rate = cbh_pkg::NO_RATE;
            s.hunt_pos  = '0;
        end else if (!i_state.running) begin
            active = 1'b0;
        end else if (accepted) begin
            if (32'(i_state.cmd_pos) == 32'(BAUD_COMMAND_SLOT)) begin
                if ((i_target >= cbh_pkg::RATE_MIN) && (i_target <= cbh_pkg::RATE_MAX)) begin
                    s.cur_rate = i_target;
                end else begin
                    s.cur_rate = cbh_pkg::NO_RATE;
                end
                s.hunt_pos = '0;
            end
            if (32'(i_state.cmd_pos) < 32'(NUM_COMMANDS)) begin
                s.cmd_pos = i_state.cmd_pos + 4'd1;
            end
        end else begin
            s.cur_rate = cbh_pkg::NO_RATE;
        end

        // Pick the next rate if needed, then the next command or the finish
        if (active) begin
            if ((s.cur_rate == cbh_pkg::NO_RATE) && (s.hunt_pos >= cbh_pkg::HUNT_LEN)) begin
                s.running         = 1'b0;
                o_result.finished = 1'b1;
            end else begin
                if (s.cur_rate == cbh_pkg::NO_RATE) begin
                    s.cur_rate = cbh_pkg::hunt_rate(s.hunt_pos[2:0]);
                    s.hunt_pos = s.hunt_pos + 4'd1;
                end
                restore     = 32'(s.cmd_pos) >= 32'(NUM_COMMANDS);
                reconf      = (s.cur_rate != s.prev_rate) || restore;
                s.prev_rate = s.cur_rate;
                if (reconf) begin
                    o_result.reconfigure_port    = 1'b1;
                    o_result.port_baud_index     = restore ? 4'd0 : s.cur_rate;
                    o_result.restore_saved_speed = restore;
                end
                if (restore) begin
                    s.running         = 1'b0;
                    o_result.finished = 1'b1;
                    o_result.success  = 1'b1;
                end else begin
                    o_result.send_command  = 1'b1;
                    o_result.command_index = s.cmd_pos[1:0];
                end
            end
        end

        o_state = s;
    end

endmodule

// ----- rtl/at_command_baud_hunt_sequencer.sv -----
// Top level of the baud-hunt command sequencer: input register, state, result register.
// Depends on cbh_pkg and cbh_step.
//
//  Channel   Dir  Ports                 Content
//  s_axis    in   tdata[15:0], tuser    reply_first, reply_second; tuser = mode
//  m_axis    out  tdata[15:0]           one result per event
//  cfg       in   i_cfg_we, wdata[3:0]  target_baud_index
//
// One event per cycle while the result side is not stalling; a request that is taken passes
// through the input register, then the step logic into the result register.
// i_rst_n is synchronous and active low; it empties both registers and idles the sequencer.
// A stalled result holds the input register; the input side stays ready while the
// input register is empty or moving on.
module at_command_baud_hunt_sequencer #(
    parameter int NUM_COMMANDS      = 4,
    parameter int BAUD_COMMAND_SLOT = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,       // target_baud_index
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,    // [7:0] reply_first, [15:8] reply_second
    input  logic [1:0]  i_s_axis_tuser,    // [1:0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata     // [0] reconfigure_port, [4:1] port_baud_index,
                                           // [5] send_command, [7:6] command_index,
                                           // [8] restore_saved_speed, [9] finished,
                                           // [10] success, [15:11] zero
);

    logic              r_in_valid, n_in_valid;
    logic [1:0]        r_mode;
    logic [7:0]        r_first;
    logic [7:0]        r_second;
    logic [3:0]        r_target;
    cbh_pkg::t_state   r_state, n_state;
    logic              r_out_valid, n_out_valid;
    cbh_pkg::t_result  r_out, n_out;
    logic              in_take;
    logic              step_en;

    // Handshake
    assign step_en         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || step_en;
    assign n_in_valid      = in_take || (r_in_valid && !step_en);
    assign n_out_valid     = step_en || (r_out_valid && !i_m_axis_tready);

    cbh_step #(
        .NUM_COMMANDS      (NUM_COMMANDS),
        .BAUD_COMMAND_SLOT (BAUD_COMMAND_SLOT)
    ) u_step (
        .i_state        (r_state),
        .i_mode         (r_mode),
        .i_reply_first  (r_first),
        .i_reply_second (r_second),
        .i_target       (r_target),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_target          <= 4'd0;
            r_state.running   <= 1'b0;
            r_state.cmd_pos   <= '0;
            r_state.cur_rate  <= cbh_pkg::NO_RATE;
            r_state.prev_rate <= cbh_pkg::NO_RATE;
            r_state.hunt_pos  <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (step_en) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode   <= i_s_axis_tuser;
            r_first  <= i_s_axis_tdata[7:0];
            r_second <= i_s_axis_tdata[15:8];
        end
        if (step_en) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

    // Sequencer only stops running with a finish result
    a_stop_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state.running) |-> (r_out_valid && r_out.finished))
        else $error("sequencer stopped without a finish result");

    // A finish never sends a command
    a_finish_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.finished) |-> (!r_out.send_command && !r_state.running))
        else $error("finish result sends a command or leaves sequencer running");

    // Restore only on success, with a reconfigure and no rate index
    a_restore_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.restore_saved_speed) |->
        (r_out.success && r_out.reconfigure_port && (r_out.port_baud_index == 4'd0)))
        else $error("restore result inconsistent");

    // A step only fires when the input register holds a request
    a_step_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $changed(r_state) |-> $past(r_in_valid))
        else $error("state changed without a request");

endmodule

// ----- tb/sv/at_command_baud_hunt_sequencer_tb.sv -----
// Self-checking testbench for at_command_baud_hunt_sequencer: directed and random event
// streams, an event-level predictor of the command and baud-hunt sequence, field checks.
// Depends on cbh_pkg and the at_command_baud_hunt_sequencer RTL.
module at_command_baud_hunt_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CMDS    = 4;
    localparam int BAUD_SLOT   = 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;

    // Event kinds with no name in the package
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    // Preferred rate order during the hunt
    localparam logic [3:0] RATE_ORDER [8] = '{4'd4, 4'd6, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd1};

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] first;
        logic [7:0] second;
    } t_link_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        ev_valid;
    logic        ev_ready;
    logic [15:0] ev_data;
    logic [1:0]  ev_mode;
    logic        act_valid;
    logic        act_ready;
    logic [15:0] act_data;

    // Stimulus and scoreboard
    t_link_event      pending_events[$];
    cbh_pkg::t_result expected_actions[$];
    int               events_left;
    int               error_count;
    int               result_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               req_taken;

    // Predictor state
    logic [3:0]  tgt_rate;
    logic        seq_running;
    logic [3:0]  seq_cmd;
    logic [3:0]  seq_rate;
    logic [3:0]  seq_prev;
    logic [3:0]  seq_hunt;

    at_command_baud_hunt_sequencer #(
        .NUM_COMMANDS      (NUM_CMDS),
        .BAUD_COMMAND_SLOT (BAUD_SLOT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (ev_valid),
        .o_s_axis_tready (ev_ready),
        .i_s_axis_tdata  (ev_data),
        .i_s_axis_tuser  (ev_mode),
        .o_m_axis_tvalid (act_valid),
        .i_m_axis_tready (act_ready),
        .o_m_axis_tdata  (act_data)
    );

    // Picks the next rate if needed, then either sends a command or ends the sequence
    function automatic cbh_pkg::t_result next_action();
        cbh_pkg::t_result r;
        logic             restore;
        logic             reconf;
        r = '0;
        if (seq_rate == cbh_pkg::NO_RATE) begin
            if (seq_hunt >= cbh_pkg::HUNT_LEN) begin
                seq_running = 1'b0;
                r.finished  = 1'b1;
                return r;
            end
            seq_rate = RATE_ORDER[seq_hunt[2:0]];
            seq_hunt = seq_hunt + 4'd1;
        end
        restore  = (seq_cmd >= NUM_CMDS);
        reconf   = (seq_rate != seq_prev) || restore;
        seq_prev = seq_rate;
        if (reconf) begin
            r.reconfigure_port    = 1'b1;
            r.port_baud_index     = restore ? 4'd0 : seq_rate;
            r.restore_saved_speed = restore;
        end
        if (restore) begin
            seq_running = 1'b0;
            r.finished  = 1'b1;
            r.success   = 1'b1;
            return r;
        end
        r.send_command  = 1'b1;
        r.command_index = seq_cmd[1:0];
        return r;
    endfunction

    // Expected action for one link event; updates the predictor state
    function automatic cbh_pkg::t_result predict_action(input t_link_event ev);
        logic ack;
        if (ev.mode == cbh_pkg::MODE_START) begin
            seq_running = 1'b1;
            seq_cmd     = 4'd0;
            seq_rate    = cbh_pkg::NO_RATE;
            seq_prev    = cbh_pkg::NO_RATE;
            seq_hunt    = 4'd0;
            return next_action();
        end
        if (!seq_running)
            return '0;
        ack = (ev.mode == cbh_pkg::MODE_REPLY) &&
              ((ev.first == cbh_pkg::CH_O && ev.second == cbh_pkg::CH_K) ||
               (ev.first == cbh_pkg::CH_PLUS && ev.second >= cbh_pkg::CH_A &&
                ev.second <= cbh_pkg::CH_Z));
        if (ack) begin
            // baud command acknowledged: adopt the target if it is in range, and restart the hunt
            if (seq_cmd == BAUD_SLOT) begin
                seq_rate = (tgt_rate >= cbh_pkg::RATE_MIN && tgt_rate <= cbh_pkg::RATE_MAX) ?
                           tgt_rate : cbh_pkg::NO_RATE;
                seq_hunt = 4'd0;
            end
            if (seq_cmd < NUM_CMDS)
                seq_cmd = seq_cmd + 4'd1;
        end else begin
            seq_rate = cbh_pkg::NO_RATE;
        end
        return next_action();
    endfunction

    function automatic t_link_event make_event(input logic [1:0] m, input logic [7:0] a,
                                               input logic [7:0] b);
        t_link_event ev;
        ev.mode   = m;
        ev.first  = a;
        ev.second = b;
        return ev;
    endfunction

    // A reply that acknowledges the command
    function automatic t_link_event ack_reply();
        if ($urandom_range(0, 1) == 0)
            return make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K);
        return make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_PLUS,
                          8'($urandom_range(cbh_pkg::CH_A, cbh_pkg::CH_Z)));
    endfunction

    // A timeout, a spare mode or a reply that is close to an acknowledge; random bytes may still form one
    function automatic t_link_event nak_reply();
        logic [7:0] near;
        near = ($urandom_range(0, 1) == 0) ? 8'h40 : 8'h5B;
        case ($urandom_range(0, 4))
            0:       return make_event(MODE_TIMEOUT, 8'($urandom), 8'($urandom));
            1:       return make_event(MODE_SPARE, 8'($urandom), 8'($urandom));
            2:       return make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, 8'($urandom));
            3:       return make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_PLUS, near);
            default: return make_event(cbh_pkg::MODE_REPLY, 8'($urandom), 8'($urandom));
        endcase
    endfunction

    task automatic queue_event(input t_link_event ev);
        pending_events.push_back(ev);
        events_left++;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on result %0d: %s = %0d, expected %0d", result_count, field, got, want);
        error_count++;
    endtask

    // Waits until every queued request is taken and every result has come back
    task automatic wait_drained();
        while (events_left != 0 || expected_actions.size() != 0)
            @(negedge i_clk);
    endtask

    // Target rate is written only while the request and result streams are idle; the sequencer may still be running
    task automatic write_target(input logic [3:0] v);
        wait_drained();
        repeat (4) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        tgt_rate   = v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed sequences from a start, some noise and broken sequences
    task automatic queue_random(input int n);
        int added;
        int len;
        int ack_pct;
        int pick;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0:       ack_pct = 90;
                    1:       ack_pct = 60;
                    default: ack_pct = 15;
                endcase
                len = $urandom_range(1, 12);
                queue_event(make_event(cbh_pkg::MODE_START, 8'($urandom), 8'($urandom)));
                added++;
                repeat (len) begin
                    if ($urandom_range(0, 99) < ack_pct)
                        queue_event(ack_reply());
                    else
                        queue_event(nak_reply());
                    added++;
                end
            end else if (pick < 90) begin
                queue_event(make_event(2'($urandom), 8'($urandom), 8'($urandom)));
                added++;
            end else begin
                len = $urandom_range(1, 6);
                queue_event(make_event(cbh_pkg::MODE_START, 8'($urandom), 8'($urandom)));
                added++;
                repeat (len) begin
                    queue_event(make_event(2'($urandom_range(1, 3)), 8'($urandom),
                                           8'($urandom)));
                    added++;
                end
            end
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Request driver: presents the next queued event once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!ev_valid || req_taken) begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_link_event ev;
                    ev = pending_events.pop_front();
                    ev_mode  <= ev.mode;
                    ev_data  <= {ev.second, ev.first};
                    ev_valid <= 1'b1;
                end else begin
                    ev_valid <= 1'b0;
                end
            end
            act_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on every taken request, checks every taken result
    always @(posedge i_clk) begin : monitor
        cbh_pkg::t_result got;
        cbh_pkg::t_result want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (ev_valid && ev_ready) begin
                expected_actions.push_back(predict_action({ev_mode, ev_data[7:0],
                                                           ev_data[15:8]}));
                events_left--;
                req_taken = 1'b1;
            end
            if (act_valid && act_ready) begin
                got = act_data[10:0];
                if (expected_actions.size() == 0) begin
                    report_mismatch("unexpected result, tdata", act_data, 0);
                end else begin
                    want = expected_actions.pop_front();
                    if (got.reconfigure_port !== want.reconfigure_port)
                        report_mismatch("reconfigure_port", got.reconfigure_port,
                                        want.reconfigure_port);
                    if (got.port_baud_index !== want.port_baud_index)
                        report_mismatch("port_baud_index", got.port_baud_index,
                                        want.port_baud_index);
                    if (got.send_command !== want.send_command)
                        report_mismatch("send_command", got.send_command, want.send_command);
                    if (got.command_index !== want.command_index)
                        report_mismatch("command_index", got.command_index, want.command_index);
                    if (got.restore_saved_speed !== want.restore_saved_speed)
                        report_mismatch("restore_saved_speed", got.restore_saved_speed,
                                        want.restore_saved_speed);
                    if (got.finished !== want.finished)
                        report_mismatch("finished", got.finished, want.finished);
                    if (got.success !== want.success)
                        report_mismatch("success", got.success, want.success);
                    if (act_data[15:11] !== 5'd0)
                        report_mismatch("padding", act_data[15:11], 0);
                end
                result_count++;
            end
        end
    end

    // Main sequence: reset, directed events, random phases over several targets
    initial begin
        logic [3:0] targets [6];
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 4'd0;
        ev_valid      = 1'b0;
        ev_data       = 16'd0;
        ev_mode       = 2'd0;
        act_ready     = 1'b0;
        events_left   = 0;
        error_count   = 0;
        result_count  = 0;
        cycle_count   = 0;
        send_idle_pct = 8;
        recv_idle_pct = 53;
        req_taken     = 1'b0;
        tgt_rate      = 4'd0;
        seq_running   = 1'b0;
        seq_cmd       = 4'd0;
        seq_rate      = cbh_pkg::NO_RATE;
        seq_prev      = cbh_pkg::NO_RATE;
        seq_hunt      = 4'd0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_target(4'd8);

        // replies while idle are ignored
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(MODE_TIMEOUT, 8'hFF, 8'hFF));
        queue_event(make_event(MODE_SPARE, 8'h00, 8'h00));
        // full success run, the baud command acknowledged with a '+' reply
        queue_event(make_event(cbh_pkg::MODE_START, 8'hFF, 8'hFF));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_PLUS, cbh_pkg::CH_Z));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_PLUS, cbh_pkg::CH_A));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        // every rate rejected: near misses, spare mode, timeout, extreme bytes
        queue_event(make_event(cbh_pkg::MODE_START, 8'h00, 8'h00));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_PLUS, 8'h40));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_PLUS, 8'h5B));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, 8'h6B));
        queue_event(make_event(MODE_SPARE, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(MODE_TIMEOUT, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_REPLY, 8'h00, 8'h00));
        queue_event(make_event(cbh_pkg::MODE_REPLY, 8'hFF, 8'hFF));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_K, cbh_pkg::CH_O));
        // restart while running, then a reject after the baud command
        queue_event(make_event(cbh_pkg::MODE_START, 8'h55, 8'hAA));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_START, 8'hAA, 8'h55));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(MODE_TIMEOUT, 8'h00, 8'hFF));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));

        // out-of-table target: the hunt restarts from the head after the baud command
        write_target(4'd0);
        queue_event(make_event(cbh_pkg::MODE_START, 8'h00, 8'h00));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));
        queue_event(make_event(cbh_pkg::MODE_REPLY, cbh_pkg::CH_O, cbh_pkg::CH_K));

        targets = '{4'd1, 4'd15, 4'd9, 4'd8, 4'($urandom), 4'($urandom_range(1, 8))};
        for (int p = 0; p < 6; p++) begin
            write_target(targets[p]);
            // idle pattern: sender light first, then receiver light, then none
            if (p < 2) begin
                send_idle_pct = 8;
                recv_idle_pct = 53;
            end else if (p < 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cbh_pkg.sv
rtl/cbh_step.sv
rtl/at_command_baud_hunt_sequencer.sv
tb/sv/at_command_baud_hunt_sequencer_tb.sv
